[src/sprite_entry_tile_decoder_assert.svh]
// Assertion macros shared by the sprite entry tile decoder modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SPRITE_ENTRY_TILE_DECODER_ASSERT_SVH
`define SPRITE_ENTRY_TILE_DECODER_ASSERT_SVH

// Condition must never hold at a clock edge outside reset.
`define SETD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Precondition in one cycle implies the postcondition in the next cycle.
`define SETD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/setd_pkg.sv]
// Package for the sprite entry tile decoder: constants and the queued entry type.
// Depends on nothing; used by every module of the block.
package setd_pkg;

    localparam int unsigned SETD_QUEUE_DEPTH = 2;

    localparam logic [9:0]  SX_WRAP_LIMIT = 10'd320;
    localparam logic [9:0]  SY_WRAP_LIMIT = 10'd256;
    localparam logic [9:0]  WRAP_SPAN     = 10'd512;
    localparam logic signed [10:0] SX_MIRROR   = 11'sd304;
    localparam logic signed [10:0] SY_MIRROR   = 11'sd240;
    localparam logic signed [10:0] SX_LIMIT_HI = 11'sd320;
    localparam logic signed [10:0] SX_LIMIT_LO = -11'sd15;
    localparam logic signed [10:0] Y_OFFSET    = 11'sd8;

    localparam logic [1:0] APB_ADDR_W = 2'd3;
    localparam logic       REG_FLIP_SCREEN = 1'b0;

    // One accepted, visible entry, fully decoded and waiting for the tile sequencer.
    typedef struct packed {
        logic [13:0]        code_base;  // tile code with the group bits cleared
        logic [2:0]         last_idx;   // tiles in the run minus one
        logic               flip_y_src; // entry's own y flip, picks code order
        logic               flip_scr;   // flip_screen at decode, picks y step sign
        logic signed [9:0]  x_pos;
        logic signed [10:0] y_base;     // screen y of tile 0, offset included
        logic               mirror_x;
        logic               mirror_y;
        logic [4:0]         palette;
    } setd_entry_t;

    // Status of the queue as seen by the sequencer.
    typedef struct packed {
        logic        valid;
        setd_entry_t head;
    } setd_q_status_t;

endpackage

[src/setd_front.sv]
// Front end of the sprite entry tile decoder: classifies and decodes one entry.
// Depends on setd_pkg.
module setd_front
    import setd_pkg::*;
(
    input  logic        flip_screen,
    input  logic [15:0] y_word,
    input  logic [15:0] code_word,
    input  logic [15:0] x_word,
    input  logic        frame_odd,
    output logic        visible,
    output setd_entry_t entry
);

    logic [8:0]         sx_raw;
    logic [8:0]         sy_raw;
    logic signed [10:0] sx_wrap;
    logic signed [10:0] sy_wrap;
    logic signed [10:0] sx_final;
    logic signed [10:0] sy_final;
    logic [2:0]         last_idx;
    logic               on_screen;

    assign sx_raw = x_word[8:0];
    assign sy_raw = y_word[8:0];

    // Nine-bit positions past the wrap point become negative.
    assign sx_wrap = ({1'b0, sx_raw} >= SX_WRAP_LIMIT)
                   ? $signed({1'b1, {1'b0, sx_raw} - WRAP_SPAN})
                   : $signed({2'b00, sx_raw});
    assign sy_wrap = ({1'b0, sy_raw} >= SY_WRAP_LIMIT)
                   ? $signed({1'b1, {1'b0, sy_raw} - WRAP_SPAN})
                   : $signed({2'b00, sy_raw});

    // Flip-screen undoes the mirror, so the wrapped value is used directly.
    always_comb
    begin
        if (flip_screen)
        begin
            sx_final = sx_wrap;
            sy_final = sy_wrap;
        end
        else
        begin
            sx_final = SX_MIRROR - sx_wrap;
            sy_final = SY_MIRROR - sy_wrap;
        end
    end

    always_comb
    begin
        unique case (y_word[10:9])
            2'd0:    last_idx = 3'd0;
            2'd1:    last_idx = 3'd1;
            2'd2:    last_idx = 3'd3;
            default: last_idx = 3'd7;
        endcase
    end

    assign on_screen = (sx_final < SX_LIMIT_HI) && (sx_final >= SX_LIMIT_LO);
    assign visible   = (code_word != 16'd0) && !(y_word[12] && frame_odd) && on_screen;

    always_comb
    begin
        entry.code_base  = code_word[13:0] & ~{11'd0, last_idx};
        entry.last_idx   = last_idx;
        entry.flip_y_src = y_word[14];
        entry.flip_scr   = flip_screen;
        entry.x_pos      = sx_final[9:0];
        entry.y_base     = sy_final - Y_OFFSET;
        entry.mirror_x   = y_word[13] ^ flip_screen;
        entry.mirror_y   = y_word[14] ^ flip_screen;
        entry.palette    = x_word[13:9];
    end

endmodule

[src/setd_queue.sv]
// Short entry queue between the decode front end and the tile sequencer.
// Depends on setd_pkg and the assertion macro header.
`include "sprite_entry_tile_decoder_assert.svh"

module setd_queue
    import setd_pkg::*;
#(
    parameter int unsigned DEPTH = SETD_QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  setd_entry_t    push_entry,
    input  logic           pop,
    output logic           full,
    output setd_q_status_t status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    setd_entry_t      slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full         = (count_reg == DEPTH_CNT);
    assign status.valid = (count_reg != '0);
    assign status.head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `SETD_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full, "push into full queue")
    `SETD_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && !status.valid, "pop from empty queue")
    `SETD_ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > DEPTH_CNT, "queue count out of range")

endmodule

[src/setd_back.sv]
// Tile sequencer of the sprite entry tile decoder: walks one entry's tile stack.
// Depends on setd_pkg and the assertion macro header.
`include "sprite_entry_tile_decoder_assert.svh"

module setd_back
    import setd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  setd_q_status_t     status,
    output logic               pop,
    output logic               tile_valid,
    output logic [13:0]        tile_code,
    output logic signed [9:0]  x_pos,
    output logic signed [10:0] y_pos,
    output logic               mirror_x,
    output logic               mirror_y,
    output logic [4:0]         palette_bank,
    output logic               last_tile
);

    setd_entry_t        cur_reg;
    logic               active_reg;
    logic [2:0]         idx_reg;
    logic               load;

    logic [2:0]         code_off;
    logic signed [10:0] y_step;
    logic signed [10:0] y_tile;

    logic               valid_reg;
    logic [13:0]        code_reg;
    logic signed [9:0]  x_reg;
    logic signed [10:0] y_reg;
    logic               mx_reg;
    logic               my_reg;
    logic [4:0]         pal_reg;
    logic               last_reg;

    // A new entry is taken when idle or on the final tile of the current run.
    assign load = status.valid && (!active_reg || (idx_reg == 3'd0));
    assign pop  = load;

    // Tiles run from the far end of the stack down to index zero.
    assign code_off = cur_reg.flip_y_src ? idx_reg : (cur_reg.last_idx - idx_reg);
    assign y_step   = $signed({4'd0, idx_reg, 4'd0});
    assign y_tile   = cur_reg.flip_scr ? (cur_reg.y_base + y_step)
                                       : (cur_reg.y_base - y_step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= 3'd0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= active_reg;
            if (load)
            begin
                active_reg <= 1'b1;
                idx_reg    <= status.head.last_idx;
            end
            else if (active_reg)
            begin
                if (idx_reg == 3'd0)
                begin
                    active_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg - 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= status.head;
        end
        code_reg <= cur_reg.code_base | {11'd0, code_off};
        x_reg    <= cur_reg.x_pos;
        y_reg    <= y_tile;
        mx_reg   <= cur_reg.mirror_x;
        my_reg   <= cur_reg.mirror_y;
        pal_reg  <= cur_reg.palette;
        last_reg <= (idx_reg == 3'd0);
    end

    assign tile_valid   = valid_reg;
    assign tile_code    = code_reg;
    assign x_pos        = x_reg;
    assign y_pos        = y_reg;
    assign mirror_x     = mx_reg;
    assign mirror_y     = my_reg;
    assign palette_bank = pal_reg;
    assign last_tile    = last_reg;

    `SETD_ASSERT_NEXT(a_run_continues, clk, rst_n, valid_reg && !last_reg, valid_reg,
        "tile run broken before its last tile")
    `SETD_ASSERT_NEXT(a_idx_counts_down, clk, rst_n, active_reg && (idx_reg != 3'd0),
        active_reg && (idx_reg == $past(idx_reg) - 3'd1), "tile index did not step down")
    `SETD_ASSERT_NEXT(a_idle_after_run, clk, rst_n,
        active_reg && (idx_reg == 3'd0) && !status.valid, !active_reg,
        "sequencer stayed busy after its final tile")

endmodule

[src/sprite_entry_tile_decoder.sv]
// Top level of the sprite entry tile decoder: APB register, front end, queue, sequencer.
// Depends on setd_pkg, setd_front, setd_queue and setd_back.
//
//  Channel   | Handshake                        | Payload
//  ----------+----------------------------------+----------------------------------------
//  entry in  | start, busy                      | y_word, code_word, x_word, frame_odd
//  tile out  | tile_valid (one-cycle strobe)    | tile_code, x_pos, y_pos, mirror_x,
//            |                                  | mirror_y, palette_bank, last_tile
//  config    | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// An entry is decoded in the cycle it is accepted and lands in a two-entry queue, so a
// transaction is taken whenever the queue has room; busy means the queue is full.
// The tile sequencer emits one tile per cycle, 1, 2, 4 or 8 tiles per entry, and moves
// straight from the last tile of one entry to the first of the next when the queue holds
// one. An accepted entry is registered in the queue, then in the sequencer, and its first
// tile is then registered on the outputs. Dropped entries (unused, flickered out, off screen) give no tile.
// Reset clears the queue, the sequencer and flip_screen. The receiver cannot stall;
// each tile strobe is taken in the cycle it is shown.
module sprite_entry_tile_decoder
    import setd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = SETD_QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               start,
    output logic               busy,
    input  logic [15:0]        y_word,
    input  logic [15:0]        code_word,
    input  logic [15:0]        x_word,
    input  logic               frame_odd,

    output logic               tile_valid,
    output logic [13:0]        tile_code,
    output logic signed [9:0]  x_pos,
    output logic signed [10:0] y_pos,
    output logic               mirror_x,
    output logic               mirror_y,
    output logic [4:0]         palette_bank,
    output logic               last_tile
);

    logic           flip_screen_reg;
    logic           cfg_write;
    logic           reg_hit;

    logic           visible;
    setd_entry_t    front_entry;
    logic           push;
    logic           pop;
    logic           q_full;
    setd_q_status_t q_status;

    // Register index is the word address; paddr's low bits select bytes and are ignored.
    assign pready    = 1'b1;
    assign reg_hit   = (paddr[APB_ADDR_W-1] == REG_FLIP_SCREEN);
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = reg_hit ? {31'd0, flip_screen_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_screen_reg <= 1'b0;
        end
        else if (cfg_write && reg_hit)
        begin
            flip_screen_reg <= pwdata[0];
        end
    end

    // The front end decodes combinationally; invisible entries are accepted and discarded.
    setd_front u_front (
        .flip_screen (flip_screen_reg),
        .y_word      (y_word),
        .code_word   (code_word),
        .x_word      (x_word),
        .frame_odd   (frame_odd),
        .visible     (visible),
        .entry       (front_entry)
    );

    assign busy = q_full;
    assign push = start && !q_full && visible;

    setd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (front_entry),
        .pop        (pop),
        .full       (q_full),
        .status     (q_status)
    );

    setd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .status       (q_status),
        .pop          (pop),
        .tile_valid   (tile_valid),
        .tile_code    (tile_code),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .mirror_x     (mirror_x),
        .mirror_y     (mirror_y),
        .palette_bank (palette_bank),
        .last_tile    (last_tile)
    );

endmodule

[tb/sprite_entry_tile_decoder_checker.sv]
// Checker for the sprite entry tile decoder: tracks flip_screen writes, predicts the tile run
// of every accepted entry and compares each tile strobe. Depends on setd_pkg and the block ports.
module sprite_entry_tile_decoder_checker
    import setd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,

    input  logic               start,
    input  logic               busy,
    input  logic [15:0]        y_word,
    input  logic [15:0]        code_word,
    input  logic [15:0]        x_word,
    input  logic               frame_odd,

    input  logic               tile_valid,
    input  logic [13:0]        tile_code,
    input  logic signed [9:0]  x_pos,
    input  logic signed [10:0] y_pos,
    input  logic               mirror_x,
    input  logic               mirror_y,
    input  logic [4:0]         palette_bank,
    input  logic               last_tile,

    output int                 fail_count,
    output int                 tiles_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] FLIP_SCREEN_ADDR = 3'(4 * REG_FLIP_SCREEN);

    typedef struct {
        logic [13:0]        code;
        logic signed [9:0]  x;
        logic signed [10:0] y;
        logic               mx;
        logic               my;
        logic [4:0]         pal;
        logic               last;
    } tile_cmd_t;

    tile_cmd_t expected_tiles[$];
    logic      flip_model   = 1'b0;
    int        fail_total   = 0;
    int        tiles_queued = 0;

    assign fail_count    = fail_total;
    assign tiles_pending = tiles_queued;

    task automatic check_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want_v, got_v);
            fail_total++;
        end
    endtask

    // Expands one sprite entry into its tile commands, farthest tile from the base y first.
    function automatic void decode_entry(input logic [15:0] yw, input logic [15:0] cw,
                                         input logic [15:0] xw, input logic odd);
        int          sx;
        int          sy;
        int          step;
        int          span;
        logic [13:0] base;
        logic        flip_y;
        tile_cmd_t   cmd;
        if (cw == 16'd0 || (yw[12] && odd))
            return;
        span   = (1 << yw[10:9]) - 1;
        flip_y = yw[14];
        sx = int'(xw[8:0]);
        sy = int'(yw[8:0]);
        if (sx >= 320)
            sx -= 512;
        if (sy >= 256)
            sy -= 512;
        sy = 240 - sy;
        sx = 304 - sx;
        base = cw[13:0] & ~14'(span);
        if (!flip_y)
            base = base + 14'(span);
        if (flip_model) begin
            sy   = 240 - sy;
            sx   = 304 - sx;
            step = 16;
        end else begin
            step = -16;
        end
        if (sx >= 320 || sx < -15)
            return;
        cmd.mx  = yw[13] ^ flip_model;
        cmd.my  = flip_y ^ flip_model;
        cmd.pal = xw[13:9];
        cmd.x   = 10'(sx);
        for (int i = span; i >= 0; i--) begin
            cmd.code = flip_y ? base + 14'(i) : base - 14'(i);
            cmd.y    = 11'(sy + step * i - 8);
            cmd.last = (i == 0);
            expected_tiles.push_back(cmd);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        tile_cmd_t want;
        if (!rst_n) begin
            flip_model <= 1'b0;
            expected_tiles.delete();
            tiles_queued <= 0;
        end else begin
            if (tile_valid) begin
                if (expected_tiles.size() == 0) begin
                    $error("tile strobe with no tile expected: code %0d", tile_code);
                    fail_total++;
                end else begin
                    want = expected_tiles.pop_front();
                    check_field("tile_code", want.code, tile_code);
                    check_field("x_pos", want.x, x_pos);
                    check_field("y_pos", want.y, y_pos);
                    check_field("mirror_x", want.mx, mirror_x);
                    check_field("mirror_y", want.my, mirror_y);
                    check_field("palette_bank", want.pal, palette_bank);
                    check_field("last_tile", want.last, last_tile);
                end
            end
            if (start && !busy)
                decode_entry(y_word, code_word, x_word, frame_odd);
            if (psel && penable && pwrite && pready && paddr == FLIP_SCREEN_ADDR)
                flip_model <= pwdata[0];
            tiles_queued <= expected_tiles.size();
        end
    end

endmodule

[tb/sprite_entry_tile_decoder_test.sv]
// Top of the sprite entry tile decoder testbench: clock, reset, entry and register stimulus.
// Depends on setd_pkg, sprite_entry_tile_decoder and sprite_entry_tile_decoder_checker.
module sprite_entry_tile_decoder_test
    import setd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Worst case is far below this: about 275 entries, each with its longest idle gap and
    // eight tiles, plus the settling pauses between register phases.
    localparam int CYCLE_LIMIT      = 100000;
    localparam int SETTLE_CYCLES    = 24;
    localparam int RANDOM_PHASES    = 4;
    localparam int ITEMS_PER_PHASE  = 63;
    localparam logic [2:0] FLIP_SCREEN_ADDR = 3'(4 * REG_FLIP_SCREEN);

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;

    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [2:0]         paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    logic               start     = 1'b0;
    logic               busy;
    logic [15:0]        y_word    = '0;
    logic [15:0]        code_word = '0;
    logic [15:0]        x_word    = '0;
    logic               frame_odd = 1'b0;

    logic               tile_valid;
    logic [13:0]        tile_code;
    logic signed [9:0]  x_pos;
    logic signed [10:0] y_pos;
    logic               mirror_x;
    logic               mirror_y;
    logic [4:0]         palette_bank;
    logic               last_tile;

    int                 fail_count;
    int                 tiles_pending;
    int                 cycle_count = 0;
    bit                 burst_mode  = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sprite_entry_tile_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .y_word       (y_word),
        .code_word    (code_word),
        .x_word       (x_word),
        .frame_odd    (frame_odd),
        .tile_valid   (tile_valid),
        .tile_code    (tile_code),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .mirror_x     (mirror_x),
        .mirror_y     (mirror_y),
        .palette_bank (palette_bank),
        .last_tile    (last_tile)
    );

    // The checker watches every channel of the block and does all prediction and comparison.
    sprite_entry_tile_decoder_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .start         (start),
        .busy          (busy),
        .y_word        (y_word),
        .code_word     (code_word),
        .x_word        (x_word),
        .frame_odd     (frame_odd),
        .tile_valid    (tile_valid),
        .tile_code     (tile_code),
        .x_pos         (x_pos),
        .y_pos         (y_pos),
        .mirror_x      (mirror_x),
        .mirror_y      (mirror_y),
        .palette_bank  (palette_bank),
        .last_tile     (last_tile),
        .fail_count    (fail_count),
        .tiles_pending (tiles_pending)
    );

    // Watchdog: a hung handshake or a missing tile ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Writes flip_screen through a setup and an access cycle. The upper data bits carry
    // random junk, since only bit 0 belongs to the register.
    task automatic write_flip_screen(input logic value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = FLIP_SCREEN_ADDR;
        pwdata  = ($urandom() & ~32'd1) | 32'(value);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Presents one entry and holds it until the block takes the transaction. The idle gap
    // in front of it is drawn per entry; in burst mode entries follow back to back, and
    // the mode flips now and then so both long stretches occur. While start is low the
    // payload carries noise, which the block must ignore.
    task automatic send_entry(input logic [15:0] yw, input logic [15:0] cw,
                              input logic [15:0] xw, input logic odd);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 15) == 0)
            burst_mode = !burst_mode;
        @(negedge clk);
        if (gap != 0)
        begin
            start     = 1'b0;
            y_word    = 16'($urandom());
            code_word = 16'($urandom());
            x_word    = 16'($urandom());
            frame_odd = 1'($urandom());
            repeat (gap) @(negedge clk);
        end
        start     = 1'b1;
        y_word    = yw;
        code_word = cw;
        x_word    = xw;
        frame_odd = odd;
        // The transaction completes at the first rising edge that sees busy low.
        do @(posedge clk); while (busy);
    endtask

    // Draws a random entry. Most are visible sprites with random content so that the tile
    // sequencer gets real work; the rest are unused words, flicker drops and x values in
    // the off-screen band.
    task automatic send_random_entry();
        logic [15:0] yw;
        logic [15:0] cw;
        logic [15:0] xw;
        logic        odd;
        yw  = 16'($urandom());
        cw  = 16'($urandom());
        xw  = 16'($urandom());
        odd = 1'($urandom());
        if ($urandom_range(0, 9) == 0)
            cw = 16'd0;
        else if (cw == 16'd0)
            cw = 16'd1;
        if ($urandom_range(0, 4) != 0)
        begin
            if ($urandom_range(0, 3) == 0)
                xw[8:0] = 9'($urandom_range(497, 511));
            else
                xw[8:0] = 9'($urandom_range(0, 319));
        end
        if ($urandom_range(0, 3) != 0)
            yw[12] = 1'b0;
        send_entry(yw, cw, xw, odd);
    endtask

    // Drops start, waits until every predicted tile has been seen, then lets the block run
    // dry: a dropped entry produces no tile, so a short pause covers any work still in flight.
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        wait (tiles_pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed entries with the screen unflipped.
        write_flip_screen(1'b0);
        // An all-zero code word marks an unused slot and gives no tiles.
        send_entry(16'hffff, 16'h0000, 16'hffff, 1'b0);
        // Only the ignored top bit set: a live entry with tile code zero.
        send_entry(16'h0000, 16'h8000, 16'h0000, 1'b0);
        // Flicker flag on an odd frame hides the sprite; on an even frame it is drawn.
        send_entry(16'h1064, 16'h0123, 16'h0050, 1'b1);
        send_entry(16'h1064, 16'h0123, 16'h0050, 1'b0);
        // Every height with both y-flip settings, so both code orders and group alignment
        // are seen at every run length.
        for (int h = 0; h < 4; h++)
        begin
            for (int fy = 0; fy < 2; fy++)
            begin
                send_entry({1'b0, 1'(fy), 2'b00, 1'b0, 2'(h), 9'd100}, 16'h3ff5,
                           {2'b00, 5'(h * 4 + fy), 9'd150}, 1'b0);
            end
        end
        // X edges: 319 lands at -15, 320 and 496 fall off screen, 497 lands at 319.
        send_entry(16'h0210, 16'h0040, 16'h013f, 1'b0);
        send_entry(16'h0210, 16'h0040, 16'h0140, 1'b0);
        send_entry(16'h0210, 16'h0040, 16'h01f0, 1'b0);
        send_entry(16'h0210, 16'h0040, 16'h01f1, 1'b0);
        send_entry(16'h2210, 16'h0041, 16'h01ff, 1'b1);
        // Y positions on both sides of the signed wrap, with the ignored bits y_word[15] and y_word[11] set.
        send_entry(16'h88ff, 16'h0500, 16'h0020, 1'b0);
        send_entry(16'h8b00, 16'h0501, 16'h0020, 1'b0);
        // Everything set: flicker on an even frame, both flips, eight tiles, code 0x3fff.
        send_entry(16'hffff, 16'hffff, 16'hffff, 1'b0);
        drain();

        // Directed entries with the screen flipped: mirror undone and both flips inverted.
        write_flip_screen(1'b1);
        send_entry(16'hffff, 16'hffff, 16'hffff, 1'b0);
        send_entry(16'h0000, 16'h8000, 16'h0000, 1'b0);
        send_entry(16'h4410, 16'h0123, 16'h013f, 1'b0);
        send_entry(16'h2610, 16'h0123, 16'h01f0, 1'b0);
        drain();

        // Random phases, alternating flip_screen between its two values.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_flip_screen(1'(phase));
            repeat (ITEMS_PER_PHASE) send_random_entry();
            drain();
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
